// ===== design/pidc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidc_pkg
// Types, constants and helpers shared by the implant-decay correlator files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

    localparam int GRID_SIZE    = 16;
    localparam int NEIGHBORHOOD = 3;
    localparam int TIME_BITS    = 48;
    localparam int CELLS        = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W       = $clog2(CELLS);
    localparam int HALF         = (NEIGHBORHOOD - 1) / 2;

    localparam logic [TIME_BITS-1:0] PICK_LIMIT_NS = TIME_BITS'(64'd1000000000000);

    // configuration register indexes
    localparam logic [1:0] CFG_IMPL_E_MIN = 2'd0;
    localparam logic [1:0] CFG_DYN_MAX    = 2'd1;
    localparam logic [1:0] CFG_DEC_WIN    = 2'd2;
    localparam logic [1:0] CFG_GAM_WIN    = 2'd3;

    // result flags
    localparam logic [3:0] FLG_NONE      = 4'd0;
    localparam logic [3:0] FLG_BAD_IMPL  = 4'd1;
    localparam logic [3:0] FLG_BAD_DEC   = 4'd2;
    localparam logic [3:0] FLG_IMPLANT   = 4'd3;
    localparam logic [3:0] FLG_DEC_CORR  = 4'd4;
    localparam logic [3:0] FLG_BAD_ITIME = 4'd5;
    localparam logic [3:0] FLG_WIN_EXC   = 4'd7;
    localparam logic [3:0] FLG_CLEARED   = 4'd8;

    // gamma kinds
    localparam logic [1:0] GAM_NONE = 2'd0;
    localparam logic [1:0] GAM_GE   = 2'd1;
    localparam logic [1:0] GAM_LABR = 2'd2;
    localparam logic [1:0] GAM_CLYC = 2'd3;

    typedef logic signed [6:0] t_coord;

    typedef struct packed {
        logic        req_type;
        logic [47:0] event_time_ns;
        logic        pin_any_hit;
        logic        pin_first_single;
        logic        pixel_hit;
        logic        dynode_overflow;
        logic [15:0] pin_energy;
        logic [15:0] dynode_energy;
        logic [4:0]  pos_x;
        logic [4:0]  pos_y;
        logic [2:0]  gamma_hits;
        logic [63:0] ion_tag;
    } t_in_req;

    typedef struct packed {
        logic [3:0]  event_flag;
        logic [47:0] delta_time_ns;
        logic [4:0]  match_x;
        logic [4:0]  match_y;
        logic [3:0]  neighbor_count;
        logic [63:0] ion_tag_out;
        logic [47:0] prior_gap_ns;
        logic [15:0] decay_count;
        logic [1:0]  gamma_kind;
        logic        gamma_found;
    } t_out_res;

    typedef struct packed {
        logic                 implanted;
        logic [TIME_BITS-1:0] itime;
        logic [TIME_BITS-1:0] gap;
        logic [63:0]          tag;
        logic [15:0]          dcnt;
    } t_cell;

    localparam int CELL_W = $bits(t_cell);

    typedef enum logic [1:0] {K_NONE, K_IMPL, K_DEC, K_GAM} t_kind;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_START, S_IMP, S_SCAN, S_FIN, S_DONE
    } t_state;

    function automatic logic on_table(input t_coord x, input t_coord y);
        return x >= 7'sd1 && x <= 7'(GRID_SIZE) && y >= 7'sd1 && y <= 7'(GRID_SIZE);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input t_coord x, input t_coord y);
        return ADDR_W'((int'(x) - 1) * GRID_SIZE + (int'(y) - 1));
    endfunction

endpackage

`default_nettype wire

// ===== design/pidc_ram.sv =====
// ----------------------------------------------------------------------------
// pidc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pidc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/pixel_implant_decay_correlator.sv =====
// ----------------------------------------------------------------------------
// pixel_implant_decay_correlator
// Pixel table of implants; classifies events, correlates decays and gammas.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in        request    i_in_valid/o_in_stall  i_in  (t_in_req)
// out       result     o_out_valid/i_out_stall o_out (t_out_res)
// cfg       write      i_cfg_we               i_cfg_idx, i_cfg_data
//
// one request at a time; a table RAM with one write and one read port, one read a
// cycle, paces the work: a decay scans NEIGHBORHOOD^2 cells, a gamma-only request
// scans all CELLS cells (both skip the final step with no match), and a clear
// writes all CELLS cells; every result may also wait on the output.
// after reset a clearing pass over all CELLS cells runs before the first request.
// the result sits in an output register; a stalled result holds the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pixel_implant_decay_correlator
    import pidc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_req  i_in,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_res      o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [47:0] i_cfg_data
);

    t_state r_state, n_state;
    t_in_req r_req, n_req;
    t_kind r_kind, n_kind;
    logic [15:0] r_emin, r_dmax;
    logic [47:0] r_dwin, r_gwin;
    t_coord r_cx, n_cx, r_cy, n_cy, r_y0, n_y0, r_xend, n_xend, r_yend, n_yend;
    t_coord r_pxp, n_pxp, r_pyp, n_pyp, r_bx, n_bx, r_by, n_by;
    logic r_act, n_act, r_pend, n_pend, r_found, n_found;
    logic [47:0] r_best, n_best;
    logic [3:0] r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_cidx, n_cidx;
    logic r_clr_out, n_clr_out;
    t_out_res r_res, n_res;
    logic r_ovalid, n_ovalid;
    t_out_res r_out, n_out;

    logic ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    t_cell ram_wcell, rcell;
    logic [CELL_W-1:0] ram_rdata;

    logic has_pin, is_impl, is_dec, is_gam;
    t_kind acc_kind;
    t_coord px, py;
    logic [47:0] age;
    logic [1:0] gkind;

    pidc_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wcell),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rcell       = t_cell'(ram_rdata);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    // event classification at accept
    always_comb begin
        has_pin = i_in.pin_any_hit | i_in.pin_first_single;
        is_impl = i_in.pin_first_single & i_in.pixel_hit & (i_in.pin_energy > r_emin);
        is_dec  = ~has_pin & i_in.pixel_hit & ~i_in.dynode_overflow
                & (i_in.dynode_energy < r_dmax);
        is_gam  = ~has_pin & ~i_in.pixel_hit & $onehot(i_in.gamma_hits);
        if (is_impl) begin
            acc_kind = K_IMPL;
        end else if (is_dec) begin
            acc_kind = K_DEC;
        end else if (is_gam) begin
            acc_kind = K_GAM;
        end else begin
            acc_kind = K_NONE;
        end
    end

    assign px  = t_coord'({2'b00, r_req.pos_x});
    assign py  = t_coord'({2'b00, r_req.pos_y});
    assign age = r_req.event_time_ns - rcell.itime;

    always_comb begin
        case (r_req.gamma_hits)
            3'b001:  gkind = GAM_GE;
            3'b010:  gkind = GAM_LABR;
            3'b100:  gkind = GAM_CLYC;
            default: gkind = GAM_NONE;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_req = r_req; n_kind = r_kind;
        n_cx = r_cx; n_cy = r_cy; n_y0 = r_y0; n_xend = r_xend; n_yend = r_yend;
        n_pxp = r_pxp; n_pyp = r_pyp; n_bx = r_bx; n_by = r_by;
        n_act = r_act; n_pend = r_pend; n_found = r_found; n_best = r_best;
        n_cnt = r_cnt; n_cidx = r_cidx; n_clr_out = r_clr_out; n_res = r_res;
        n_ovalid = r_ovalid; n_out = r_out;
        ram_we = 1'b0; ram_waddr = cell_addr(px, py); ram_raddr = cell_addr(px, py);
        ram_wcell = '0;

        // output register drains independently
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                ram_waddr = r_cidx;
                ram_wcell = '0;
                n_cidx = r_cidx + 1'b1;
                if (r_cidx == ADDR_W'(CELLS - 1)) begin
                    n_cidx = '0;
                    if (r_clr_out) begin
                        n_res = '0;
                        n_res.event_flag = FLG_CLEARED;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in;
                    n_kind = acc_kind;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_res = '0;
                n_found = 1'b0;
                n_best = PICK_LIMIT_NS;
                n_cnt = '0;
                n_pend = 1'b0;
                if (r_req.req_type) begin
                    n_clr_out = 1'b1;
                    n_cidx = '0;
                    n_state = S_CLEAR;
                end else begin
                    case (r_kind)
                        K_IMPL: begin
                            if (!on_table(px, py)) begin
                                n_res.event_flag = FLG_BAD_IMPL;
                                n_res.match_x = r_req.pos_x;
                                n_res.match_y = r_req.pos_y;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_IMP;
                            end
                        end
                        K_DEC: begin
                            n_cx = px - 7'(HALF); n_cy = py - 7'(HALF);
                            n_y0 = py - 7'(HALF);
                            n_xend = px + 7'(HALF); n_yend = py + 7'(HALF);
                            n_act = 1'b1;
                            n_state = S_SCAN;
                        end
                        K_GAM: begin
                            n_cx = 7'sd1; n_cy = 7'sd1; n_y0 = 7'sd1;
                            n_xend = 7'(GRID_SIZE); n_yend = 7'(GRID_SIZE);
                            n_act = 1'b1;
                            n_res.gamma_kind = gkind;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_IMP: begin
                ram_we = 1'b1;
                ram_wcell = rcell;
                ram_wcell.implanted = 1'b1;
                if (r_req.event_time_ns > rcell.itime) begin
                    ram_wcell.itime = r_req.event_time_ns;
                    ram_wcell.gap = age;
                    ram_wcell.tag = r_req.ion_tag;
                    n_res.event_flag = FLG_IMPLANT;
                    n_res.delta_time_ns = age;
                    n_res.ion_tag_out = r_req.ion_tag;
                    n_res.prior_gap_ns = age;
                    n_res.decay_count = rcell.dcnt;
                end else begin
                    n_res.event_flag = FLG_BAD_ITIME;
                end
                n_res.match_x = r_req.pos_x;
                n_res.match_y = r_req.pos_y;
                n_state = S_DONE;
            end
            S_SCAN: begin
                // issue one read per cycle
                ram_raddr = cell_addr(r_cx, r_cy);
                n_pend = r_act & on_table(r_cx, r_cy);
                n_pxp = r_cx; n_pyp = r_cy;
                if (r_act) begin
                    if (r_cy == r_yend) begin
                        n_cy = r_y0;
                        if (r_cx == r_xend) begin
                            n_act = 1'b0;
                        end else begin
                            n_cx = r_cx + 7'sd1;
                        end
                    end else begin
                        n_cy = r_cy + 7'sd1;
                    end
                end
                // evaluate the entry read last cycle
                if (r_pend) begin
                    if (r_kind == K_DEC) begin
                        if (rcell.implanted) begin
                            if (r_cnt != 4'hf) begin
                                n_cnt = r_cnt + 4'd1;
                            end
                            if (r_req.event_time_ns > rcell.itime && age < r_best) begin
                                n_best = age; n_bx = r_pxp; n_by = r_pyp; n_found = 1'b1;
                            end
                        end
                    end else begin
                        if (rcell.itime != '0 && r_req.event_time_ns > rcell.itime
                            && age < r_gwin) begin
                            n_best = age; n_bx = r_pxp; n_by = r_pyp; n_found = 1'b1;
                        end
                    end
                end
                if (!r_act && !r_pend) begin
                    ram_raddr = cell_addr(r_bx, r_by);
                    if (r_kind == K_DEC) begin
                        n_res.neighbor_count = r_cnt;
                    end
                    if (!r_found) begin
                        if (r_kind == K_DEC) begin
                            n_res.event_flag = FLG_BAD_DEC;
                        end
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                n_res.delta_time_ns = r_best;
                n_res.match_x = r_bx[4:0];
                n_res.match_y = r_by[4:0];
                n_res.ion_tag_out = rcell.tag;
                n_res.prior_gap_ns = rcell.gap;
                n_res.decay_count = rcell.dcnt;
                ram_waddr = cell_addr(r_bx, r_by);
                ram_wcell = rcell;
                if (r_kind == K_DEC) begin
                    if (r_best < r_dwin) begin
                        n_res.event_flag = FLG_DEC_CORR;
                        if (rcell.dcnt != 16'hffff) begin
                            ram_wcell.dcnt = rcell.dcnt + 16'd1;
                            n_res.decay_count = rcell.dcnt + 16'd1;
                        end
                        ram_we = 1'b1;
                    end else begin
                        n_res.event_flag = FLG_WIN_EXC;
                    end
                end else begin
                    n_res.gamma_found = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_out = r_res;
                    n_ovalid = 1'b1;
                    n_clr_out = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cidx    <= '0;
            r_clr_out <= 1'b0;
            r_ovalid  <= 1'b0;
            r_act     <= 1'b0;
            r_pend    <= 1'b0;
            r_emin    <= 16'd9000;
            r_dmax    <= 16'd9200;
            r_dwin    <= 48'd1000000000;
            r_gwin    <= 48'd40000;
        end else begin
            r_state   <= n_state;
            r_cidx    <= n_cidx;
            r_clr_out <= n_clr_out;
            r_ovalid  <= n_ovalid;
            r_act     <= n_act;
            r_pend    <= n_pend;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IMPL_E_MIN: r_emin <= i_cfg_data[15:0];
                    CFG_DYN_MAX:    r_dmax <= i_cfg_data[15:0];
                    CFG_DEC_WIN:    r_dwin <= i_cfg_data;
                    CFG_GAM_WIN:    r_gwin <= i_cfg_data;
                    default:        r_gwin <= r_gwin;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req; r_kind <= n_kind;
        r_cx <= n_cx; r_cy <= n_cy; r_y0 <= n_y0; r_xend <= n_xend; r_yend <= n_yend;
        r_pxp <= n_pxp; r_pyp <= n_pyp; r_bx <= n_bx; r_by <= n_by;
        r_found <= n_found; r_best <= n_best; r_cnt <= n_cnt;
        r_res <= n_res; r_out <= n_out;
    end

endmodule

`default_nettype wire

// ===== verif/pidc_checker.sv =====
// ----------------------------------------------------------------------------
// pidc_checker
// Watches the request and result channels of the implant-decay correlator,
// keeps its own copy of the pixel table and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidc_checker
    import pidc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_req     i_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_res    i_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    // register copies
    logic [15:0] energy_min;
    logic [15:0] dynode_max;
    logic [47:0] decay_win;
    logic [47:0] gamma_win;

    // pixel table copy
    logic        tbl_implanted [CELLS];
    logic [47:0] tbl_time      [CELLS];
    logic [47:0] tbl_gap       [CELLS];
    logic [63:0] tbl_tag       [CELLS];
    logic [15:0] tbl_count     [CELLS];

    t_out_res expected_results[$];
    int       fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_results.size();

    function automatic int cell_index(input int x, input int y);
        return (x - 1) * GRID_SIZE + (y - 1);
    endfunction

    function automatic bit in_grid(input int x, input int y);
        return x >= 1 && x <= GRID_SIZE && y >= 1 && y <= GRID_SIZE;
    endfunction

    task automatic wipe_table();
        for (int c = 0; c < CELLS; c++) begin
            tbl_implanted[c] = 1'b0;
            tbl_time[c]      = '0;
            tbl_gap[c]       = '0;
            tbl_tag[c]       = '0;
            tbl_count[c]     = '0;
        end
    endtask

    task automatic fill_match(inout t_out_res r, input int c, input int x, input int y,
                              input logic [47:0] delta);
        r.delta_time_ns = delta;
        r.match_x       = 5'(x);
        r.match_y       = 5'(y);
        r.ion_tag_out   = tbl_tag[c];
        r.prior_gap_ns  = tbl_gap[c];
        r.decay_count   = tbl_count[c];
    endtask

    // work out the result of one request and update the table copy
    task automatic correlate_request(input t_in_req q);
        t_out_res    r;
        logic [47:0] now;
        logic [47:0] best;
        logic [47:0] age;
        bit          has_pin;
        bit          found;
        int          c;
        int          bx;
        int          by;
        int          cnt;
        int          qx;
        int          qy;
        r       = '0;
        now     = q.event_time_ns;
        qx      = int'(q.pos_x);
        qy      = int'(q.pos_y);
        has_pin = q.pin_any_hit || q.pin_first_single;
        if (q.req_type) begin
            wipe_table();
            r.event_flag = FLG_CLEARED;
        end else if (q.pin_first_single && q.pixel_hit && q.pin_energy > energy_min) begin
            if (!in_grid(qx, qy)) begin
                r.event_flag = FLG_BAD_IMPL;
                r.match_x    = q.pos_x;
                r.match_y    = q.pos_y;
            end else begin
                c = cell_index(qx, qy);
                tbl_implanted[c] = 1'b1;
                if (now > tbl_time[c]) begin
                    tbl_gap[c]  = now - tbl_time[c];
                    tbl_time[c] = now;
                    tbl_tag[c]  = q.ion_tag;
                    r.event_flag = FLG_IMPLANT;
                    fill_match(r, c, qx, qy, tbl_gap[c]);
                end else begin
                    r.event_flag = FLG_BAD_ITIME;
                    r.match_x    = q.pos_x;
                    r.match_y    = q.pos_y;
                end
            end
        end else if (!has_pin && q.pixel_hit && !q.dynode_overflow &&
                     q.dynode_energy < dynode_max) begin
            best  = PICK_LIMIT_NS;
            found = 0;
            cnt   = 0;
            bx    = 0;
            by    = 0;
            for (int i = -HALF; i <= HALF; i++) begin
                for (int j = -HALF; j <= HALF; j++) begin
                    if (in_grid(qx + i, qy + j)) begin
                        c = cell_index(qx + i, qy + j);
                        if (tbl_implanted[c]) begin
                            if (cnt < 15) cnt++;
                            if (now > tbl_time[c]) begin
                                age = now - tbl_time[c];
                                if (age < best) begin
                                    best  = age;
                                    bx    = qx + i;
                                    by    = qy + j;
                                    found = 1;
                                end
                            end
                        end
                    end
                end
            end
            r.neighbor_count = 4'(cnt);
            if (!found) begin
                r.event_flag = FLG_BAD_DEC;
            end else begin
                c = cell_index(bx, by);
                if (best < decay_win) begin
                    if (tbl_count[c] != 16'hFFFF) tbl_count[c]++;
                    r.event_flag = FLG_DEC_CORR;
                end else begin
                    r.event_flag = FLG_WIN_EXC;
                end
                fill_match(r, c, bx, by, best);
            end
        end else if (!has_pin && !q.pixel_hit &&
                     (q.gamma_hits == 3'd1 || q.gamma_hits == 3'd2 || q.gamma_hits == 3'd4)) begin
            r.gamma_kind = (q.gamma_hits == 3'd1) ? GAM_GE :
                           (q.gamma_hits == 3'd2) ? GAM_LABR : GAM_CLYC;
            for (int x = 1; x <= GRID_SIZE; x++) begin
                for (int y = 1; y <= GRID_SIZE; y++) begin
                    c = cell_index(x, y);
                    if (tbl_time[c] > 0 && now > tbl_time[c] &&
                        (now - tbl_time[c]) < gamma_win) begin
                        fill_match(r, c, x, y, now - tbl_time[c]);
                        r.gamma_found = 1'b1;
                    end
                end
            end
        end
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fails++;
    endtask

    // compare one result field by field
    task automatic check_result(input t_out_res got);
        t_out_res w;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", 64'(got.event_flag), 64'd0);
            return;
        end
        w = expected_results.pop_front();
        if (got.event_flag != w.event_flag)
            report_mismatch("event_flag", 64'(got.event_flag), 64'(w.event_flag));
        if (got.delta_time_ns != w.delta_time_ns)
            report_mismatch("delta_time_ns", 64'(got.delta_time_ns), 64'(w.delta_time_ns));
        if (got.match_x != w.match_x)
            report_mismatch("match_x", 64'(got.match_x), 64'(w.match_x));
        if (got.match_y != w.match_y)
            report_mismatch("match_y", 64'(got.match_y), 64'(w.match_y));
        if (got.neighbor_count != w.neighbor_count)
            report_mismatch("neighbor_count", 64'(got.neighbor_count),
                            64'(w.neighbor_count));
        if (got.ion_tag_out != w.ion_tag_out)
            report_mismatch("ion_tag_out", got.ion_tag_out, w.ion_tag_out);
        if (got.prior_gap_ns != w.prior_gap_ns)
            report_mismatch("prior_gap_ns", 64'(got.prior_gap_ns), 64'(w.prior_gap_ns));
        if (got.decay_count != w.decay_count)
            report_mismatch("decay_count", 64'(got.decay_count), 64'(w.decay_count));
        if (got.gamma_kind != w.gamma_kind)
            report_mismatch("gamma_kind", 64'(got.gamma_kind), 64'(w.gamma_kind));
        if (got.gamma_found != w.gamma_found)
            report_mismatch("gamma_found", 64'(got.gamma_found), 64'(w.gamma_found));
    endtask

    initial fails = 0;

    // sample channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            energy_min = 16'd9000;
            dynode_max = 16'd9200;
            decay_win  = 48'd1000000000;
            gamma_win  = 48'd40000;
            wipe_table();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IMPL_E_MIN: energy_min = i_cfg_data[15:0];
                    CFG_DYN_MAX:    dynode_max = i_cfg_data[15:0];
                    CFG_DEC_WIN:    decay_win  = i_cfg_data;
                    CFG_GAM_WIN:    gamma_win  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) check_result(i_out);
            if (i_in_valid && !i_in_stall) correlate_request(i_in);
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives requests, random result stalls and register settings into the
// implant-decay correlator; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import pidc_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_req     i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_res    o_out;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [47:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          stall_enable;
    logic [47:0] clock_ns;

    pixel_implant_decay_correlator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    pidc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in(i_in),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 300);
    endfunction

    // random result stalls
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_enable && $urandom_range(0, 3) == 0) begin
                n = gap_length();
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // valid stays high after the task returns; the next call lowers it or replaces the request, and drain lowers it
    task automatic send_request(input t_in_req q);
        int n;
        n = gap_length();
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= q;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (CELLS + 20) @(posedge i_clk);
    endtask

    function automatic t_in_req base_request();
        t_in_req q;
        q = '0;
        q.event_time_ns = clock_ns;
        q.ion_tag       = {$urandom, $urandom};
        return q;
    endfunction

    function automatic t_in_req make_implant(input int x, input int y);
        t_in_req q;
        q = base_request();
        q.pin_first_single = 1'b1;
        q.pin_any_hit      = 1'($urandom);
        q.pixel_hit        = 1'b1;
        q.dynode_overflow  = 1'($urandom);
        q.pin_energy       = 16'($urandom_range(9001, 65535));
        q.dynode_energy    = 16'($urandom);
        q.pos_x            = 5'(x);
        q.pos_y            = 5'(y);
        return q;
    endfunction

    function automatic t_in_req make_decay(input int x, input int y);
        t_in_req q;
        q = base_request();
        q.pixel_hit     = 1'b1;
        q.dynode_energy = 16'($urandom_range(0, 9199));
        q.pin_energy    = 16'($urandom);
        q.gamma_hits    = 3'($urandom);
        q.pos_x         = 5'(x);
        q.pos_y         = 5'(y);
        return q;
    endfunction

    function automatic t_in_req make_gamma();
        t_in_req q;
        q = base_request();
        q.gamma_hits = 3'(1 << $urandom_range(0, 2));
        q.pin_energy = 16'($urandom);
        return q;
    endfunction

    // random request, mostly well formed, at pixels spread over the table and sometimes off it
    function automatic t_in_req random_request();
        t_in_req q;
        int      p;
        int      x;
        int      y;
        p = $urandom_range(0, 99);
        x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        if (p < 35)      q = make_implant(x, y);
        else if (p < 70) q = make_decay(x, y);
        else if (p < 85) q = make_gamma();
        else if (p < 87) begin
            q = '0;
            q.req_type = 1'b1;
        end else begin
            q = $bits(t_in_req)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom});
            q.req_type = 1'b0;
            q.event_time_ns = clock_ns;
        end
        return q;
    endfunction

    initial begin
        t_in_req q;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_IMPL_E_MIN;
        i_cfg_data   = '0;
        stall_enable = 1'b0;
        clock_ns     = 48'd100;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: implants, decays, gammas, edges of the table
        send_request(make_implant(1, 1));
        clock_ns = clock_ns + 500;
        send_request(make_implant(16, 16));
        send_request(make_implant(16, 16));
        send_request(make_implant(0, 5));
        send_request(make_implant(17, 31));
        clock_ns = clock_ns + 1000;
        send_request(make_decay(1, 1));
        send_request(make_decay(2, 2));
        send_request(make_decay(16, 16));
        send_request(make_decay(8, 8));
        send_request(make_gamma());
        send_request(make_gamma());
        q = make_implant(4, 4);
        q.pin_energy = 16'd9000;
        send_request(q);
        q = make_decay(1, 1);
        q.dynode_overflow = 1'b1;
        send_request(q);
        q = make_decay(1, 1);
        q.pin_any_hit = 1'b1;
        send_request(q);
        q = make_gamma();
        q.gamma_hits = 3'd3;
        send_request(q);
        q = make_implant(5, 5);
        q.event_time_ns = 48'hFFFF_FFFF_FFFF;
        q.ion_tag = 64'hFFFF_FFFF_FFFF_FFFF;
        send_request(q);
        q = make_implant(5, 5);
        q.event_time_ns = '0;
        send_request(q);
        clock_ns = clock_ns + 2_000_000_000;
        send_request(make_decay(6, 6));
        q = '0;
        q.req_type = 1'b1;
        send_request(q);
        send_request(make_decay(16, 16));
        drain();

        // random phases under several register settings
        stall_enable = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_IMPL_E_MIN, 48'd0);
                    write_reg(CFG_DYN_MAX, 48'hFFFF);
                    write_reg(CFG_DEC_WIN, 48'hFFFF_FFFF_FFFF);
                    write_reg(CFG_GAM_WIN, 48'hFFFF_FFFF_FFFF);
                end
                1: begin
                    write_reg(CFG_IMPL_E_MIN, 48'hFFFF);
                    write_reg(CFG_DYN_MAX, 48'd0);
                    write_reg(CFG_DEC_WIN, 48'd0);
                    write_reg(CFG_GAM_WIN, 48'd0);
                end
                default: begin
                    write_reg(CFG_IMPL_E_MIN, 48'd9000);
                    write_reg(CFG_DYN_MAX, 48'd9200);
                    write_reg(CFG_DEC_WIN, 48'($urandom_range(1000, 20000)));
                    write_reg(CFG_GAM_WIN, 48'($urandom_range(500, 20000)));
                end
            endcase
            i_cfg_we <= 1'b0;
            for (int k = 0; k < 200; k++) begin
                case ($urandom_range(0, 9))
                    0:       clock_ns = clock_ns + 48'($urandom_range(0, 40000));
                    1:       clock_ns = clock_ns - 48'($urandom_range(0, 3000));
                    2:       clock_ns = 48'({$urandom, $urandom});
                    default: clock_ns = clock_ns + 48'($urandom_range(0, 3000));
                endcase
                send_request(random_request());
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/pidc_pkg.sv
design/pidc_ram.sv
design/pixel_implant_decay_correlator.sv
verif/pidc_checker.sv
verif/tb_top.sv
